### rtl/dll_pkg.sv
package dll_pkg;

  localparam int OP_W   = 4;
  localparam int DATA_W = 32;
  localparam int STS_W  = 2;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_FIRST      = 4'd0;
  localparam logic [OP_W-1:0] OP_NEXT       = 4'd1;
  localparam logic [OP_W-1:0] OP_LAST       = 4'd2;
  localparam logic [OP_W-1:0] OP_PREV       = 4'd3;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd4;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd5;
  localparam logic [OP_W-1:0] OP_PUSH_CUR   = 4'd6;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd7;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd8;
  localparam logic [OP_W-1:0] OP_POP_CUR    = 4'd9;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd10;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NONODE  = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
  localparam logic [STS_W-1:0] STS_IGNORED = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // take an item, issue reads at its target node
    ST_LINK,   // read data back: decide, first write pass
    ST_FETCH,  // payload of the node reached by next/prev
    ST_FIX,    // second write pass of a push
    ST_HOLD    // result waits for the output register
  } state_t;

endpackage

### rtl/dll_in_if.sv
interface dll_in_if;
  logic                        valid;
  logic                        ready;
  logic [dll_pkg::OP_W-1:0]    operation;
  logic [dll_pkg::DATA_W-1:0]  payload_in;

  modport source (output valid, operation, payload_in, input ready);
  modport sink   (input valid, operation, payload_in, output ready);
endinterface

### rtl/dll_out_if.sv
interface dll_out_if;
  logic                        valid;
  logic                        ready;
  logic [dll_pkg::DATA_W-1:0]  payload_out;
  logic [dll_pkg::STS_W-1:0]   status;
  logic [dll_pkg::CNT_W-1:0]   node_count;

  modport source (output valid, payload_out, status, node_count, input ready);
  modport sink   (input valid, payload_out, status, node_count, output ready);
endinterface

### rtl/dll_ram.sv
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/doubly_linked_list_cursor_core.sv
// Doubly linked list over a pool of CAPACITY nodes, with head, tail and cursor.
// Results come from the link pass for first, last, pops, clear, refused pushes,
// unknown codes and null steps; next, prev and pushes that link need a second pass.
// One item is in flight at a time: a new item is taken only back in idle. The memories
// are read through a register; next, prev (payload fetch) and a linking push add the pass.
// Reset (rst_n, sync): pointers null, allocator and count zero, at once; no sweep.
module doubly_linked_list_cursor_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  dll_in_if.sink      in_ch,
  dll_out_if.source   out_ch
);

  // index into the pool, and pointer width (pointer == CAPACITY means null)
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int SW = (DATA_WIDTH < dll_pkg::DATA_W) ? DATA_WIDTH : dll_pkg::DATA_W;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  function automatic logic [IW-1:0] idx(input logic [PW-1:0] p);
    return (p < NIL) ? p[IW-1:0] : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  dll_pkg::state_t state_r, state_nxt;

  logic [dll_pkg::OP_W-1:0] op_r, op_nxt;
  logic [SW-1:0]            data_r, data_nxt;
  logic [PW-1:0]            tgt_r, tgt_nxt;     // node the item works on
  logic [PW-1:0]            node_r, node_nxt;   // freshly taken node
  logic [PW-1:0]            after_r, after_nxt; // successor of the insert point

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] free_top_r, free_top_nxt;
  logic [PW-1:0] fresh_r, fresh_nxt;
  logic [PW-1:0] used_r, used_nxt;

  // output register, plus a holding copy while the output is still occupied
  logic                        out_valid_r, out_valid_nxt;
  logic [dll_pkg::DATA_W-1:0]  out_pay_r, out_pay_nxt;
  logic [dll_pkg::STS_W-1:0]   out_sts_r, out_sts_nxt;
  logic [dll_pkg::CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [dll_pkg::DATA_W-1:0]  res_pay_r, res_pay_nxt;
  logic [dll_pkg::STS_W-1:0]   res_sts_r, res_sts_nxt;
  logic [dll_pkg::CNT_W-1:0]   res_cnt_r, res_cnt_nxt;

  // ---------------------------------------------------------------------------
  // Node memories: payload, next link, prev link, and the stack of freed indices
  // ---------------------------------------------------------------------------
  logic          pay_we, nxl_we, prl_we, fre_we;
  logic [IW-1:0] pay_waddr, nxl_waddr, prl_waddr, fre_waddr;
  logic [IW-1:0] pay_raddr, lnk_raddr, fre_raddr;
  logic [SW-1:0] pay_wdata, pay_rd;
  logic [PW-1:0] nxl_wdata, prl_wdata, nxl_rd, prl_rd;
  logic [IW-1:0] fre_wdata, fre_rd;

  dll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(pay_wdata),
    .raddr(pay_raddr), .rdata(pay_rd)
  );

  dll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(nxl_we), .waddr(nxl_waddr), .wdata(nxl_wdata),
    .raddr(lnk_raddr), .rdata(nxl_rd)
  );

  dll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk(clk), .we(prl_we), .waddr(prl_waddr), .wdata(prl_wdata),
    .raddr(lnk_raddr), .rdata(prl_rd)
  );

  dll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(fre_we), .waddr(fre_waddr), .wdata(fre_wdata),
    .raddr(fre_raddr), .rdata(fre_rd)
  );

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic          accept, out_free, fin;
  logic [PW-1:0] in_tgt, step, new_node, free_dec;
  logic          tgt_ok, step_ok, head_ok, from_stack, alloc_ok, ignore;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // node an incoming item starts from
  always_comb begin
    unique case (in_ch.operation)
      dll_pkg::OP_FIRST, dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_POP_FRONT: in_tgt = head_r;
      dll_pkg::OP_LAST, dll_pkg::OP_PUSH_BACK, dll_pkg::OP_POP_BACK:    in_tgt = tail_r;
      dll_pkg::OP_NEXT, dll_pkg::OP_PREV, dll_pkg::OP_PUSH_CUR,
      dll_pkg::OP_POP_CUR:                                              in_tgt = cur_r;
      default:                                                          in_tgt = NIL;
    endcase
  end

  assign tgt_ok     = tgt_r < NIL;
  assign head_ok    = head_r < NIL;
  assign step       = (op_r == dll_pkg::OP_NEXT) ? nxl_rd : prl_rd;
  assign step_ok    = step < NIL;
  // freed indices are reused first, then never-used ones in order
  assign from_stack = free_top_r != '0;
  assign free_dec   = free_top_r - PW'(1);
  assign new_node   = from_stack ? PW'(fre_rd) : fresh_r;
  assign alloc_ok   = from_stack || (fresh_r < NIL);
  // inserting after a null cursor is only allowed on an empty list
  assign ignore     = (op_r != dll_pkg::OP_PUSH_FRONT) && !tgt_ok && head_ok;

  // link and payload reads go out in the accept cycle, at the target node
  assign lnk_raddr  = idx(in_tgt);
  assign fre_raddr  = free_dec[IW-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dll_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dll_pkg::ST_LINK;
        end
      end
      dll_pkg::ST_LINK: begin
        state_nxt = out_free ? dll_pkg::ST_IDLE : dll_pkg::ST_HOLD;
        unique case (op_r)
          dll_pkg::OP_NEXT, dll_pkg::OP_PREV: begin
            if (tgt_ok && step_ok) begin
              state_nxt = dll_pkg::ST_FETCH;
            end
          end
          dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_PUSH_BACK, dll_pkg::OP_PUSH_CUR: begin
            if (!ignore && alloc_ok) begin
              state_nxt = dll_pkg::ST_FIX;
            end
          end
          default: ;
        endcase
      end
      dll_pkg::ST_FETCH, dll_pkg::ST_FIX, dll_pkg::ST_HOLD: begin
        state_nxt = out_free ? dll_pkg::ST_IDLE : dll_pkg::ST_HOLD;
      end
      default: state_nxt = dll_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [PW-1:0] prior;
    logic [PW-1:0] after;

    prior        = prl_rd;
    after        = nxl_rd;

    op_nxt       = op_r;
    data_nxt     = data_r;
    tgt_nxt      = tgt_r;
    node_nxt     = node_r;
    after_nxt    = after_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cur_nxt      = cur_r;
    free_top_nxt = free_top_r;
    fresh_nxt    = fresh_r;
    used_nxt     = used_r;

    pay_raddr    = idx(in_tgt);
    pay_we       = 1'b0;
    pay_waddr    = '0;
    pay_wdata    = data_r;
    nxl_we       = 1'b0;
    nxl_waddr    = '0;
    nxl_wdata    = NIL;
    prl_we       = 1'b0;
    prl_waddr    = '0;
    prl_wdata    = NIL;
    fre_we       = 1'b0;
    fre_waddr    = free_top_r[IW-1:0];
    fre_wdata    = tgt_r[IW-1:0];

    fin          = 1'b0;
    res_pay_nxt  = '0;
    res_sts_nxt  = dll_pkg::STS_NONODE;

    unique case (state_r)
      dll_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_ch.operation;
          data_nxt = in_ch.payload_in[SW-1:0];
          tgt_nxt  = in_tgt;
        end
      end

      dll_pkg::ST_LINK: begin
        unique case (op_r)
          dll_pkg::OP_FIRST, dll_pkg::OP_LAST: begin
            fin = 1'b1;
            if (tgt_ok) begin
              cur_nxt     = tgt_r;
              res_pay_nxt = dll_pkg::DATA_W'(pay_rd);
              res_sts_nxt = dll_pkg::STS_OK;
            end
          end

          dll_pkg::OP_NEXT, dll_pkg::OP_PREV: begin
            if (tgt_ok && step_ok) begin
              pay_raddr = idx(step);
              tgt_nxt   = step;
            end else begin
              fin = 1'b1;
            end
          end

          dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_PUSH_BACK, dll_pkg::OP_PUSH_CUR: begin
            if (ignore) begin
              fin         = 1'b1;
              res_sts_nxt = dll_pkg::STS_IGNORED;
            end else if (!alloc_ok) begin
              fin         = 1'b1;
              res_sts_nxt = dll_pkg::STS_FULL;
            end else begin
              if (from_stack) begin
                free_top_nxt = free_dec;
              end else begin
                fresh_nxt = fresh_r + PW'(1);
              end
              used_nxt  = used_r + PW'(1);
              node_nxt  = new_node;
              pay_we    = 1'b1;
              pay_waddr = idx(new_node);
              nxl_we    = 1'b1;
              nxl_waddr = idx(new_node);
              prl_we    = 1'b1;
              prl_waddr = idx(new_node);
              if (op_r == dll_pkg::OP_PUSH_FRONT) begin
                // new head; old head's prev link is fixed in the second pass
                nxl_wdata = head_r;
                head_nxt  = new_node;
                if (!head_ok) begin
                  tail_nxt = new_node;
                end
              end else begin
                cur_nxt = new_node;
                if (tgt_ok) begin
                  nxl_wdata = after;
                  prl_wdata = tgt_r;
                  after_nxt = after;
                  if (!(after < NIL)) begin
                    tail_nxt = new_node;
                  end
                end else begin
                  // empty list: the node is head, tail and cursor
                  after_nxt = NIL;
                  head_nxt  = new_node;
                  tail_nxt  = new_node;
                end
              end
            end
          end

          dll_pkg::OP_POP_FRONT, dll_pkg::OP_POP_BACK, dll_pkg::OP_POP_CUR: begin
            fin = 1'b1;
            if (tgt_ok) begin
              res_pay_nxt = dll_pkg::DATA_W'(pay_rd);
              res_sts_nxt = dll_pkg::STS_OK;
              if (prior < NIL) begin
                nxl_we    = 1'b1;
                nxl_waddr = idx(prior);
                nxl_wdata = after;
              end else begin
                head_nxt = after;
              end
              if (after < NIL) begin
                prl_we    = 1'b1;
                prl_waddr = idx(after);
                prl_wdata = prior;
                cur_nxt   = after;
              end else begin
                tail_nxt = prior;
                cur_nxt  = NIL;
              end
              if (free_top_r < NIL) begin
                fre_we       = 1'b1;
                free_top_nxt = free_top_r + PW'(1);
              end
              if (used_r != '0) begin
                used_nxt = used_r - PW'(1);
              end
            end
          end

          dll_pkg::OP_CLEAR: begin
            fin          = 1'b1;
            res_sts_nxt  = dll_pkg::STS_OK;
            head_nxt     = NIL;
            tail_nxt     = NIL;
            cur_nxt      = NIL;
            free_top_nxt = '0;
            fresh_nxt    = '0;
            used_nxt     = '0;
          end

          default: fin = 1'b1;
        endcase
      end

      dll_pkg::ST_FETCH: begin
        fin         = 1'b1;
        cur_nxt     = tgt_r;
        res_pay_nxt = dll_pkg::DATA_W'(pay_rd);
        res_sts_nxt = dll_pkg::STS_OK;
      end

      dll_pkg::ST_FIX: begin
        fin         = 1'b1;
        res_sts_nxt = dll_pkg::STS_OK;
        if (op_r == dll_pkg::OP_PUSH_FRONT) begin
          if (tgt_ok) begin
            prl_we    = 1'b1;
            prl_waddr = idx(tgt_r);
            prl_wdata = node_r;
          end
        end else if (tgt_ok) begin
          nxl_we    = 1'b1;
          nxl_waddr = idx(tgt_r);
          nxl_wdata = node_r;
          if (after_r < NIL) begin
            prl_we    = 1'b1;
            prl_waddr = idx(after_r);
            prl_wdata = node_r;
          end
        end
      end

      dll_pkg::ST_HOLD: ;

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result path: straight into the output register, or parked until it drains
  // ---------------------------------------------------------------------------
  assign res_cnt_nxt = dll_pkg::CNT_W'(used_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pay_nxt   = out_pay_r;
    out_sts_nxt   = out_sts_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_free && fin) begin
      out_valid_nxt = 1'b1;
      out_pay_nxt   = res_pay_nxt;
      out_sts_nxt   = res_sts_nxt;
      out_cnt_nxt   = res_cnt_nxt;
    end else if (out_free && (state_r == dll_pkg::ST_HOLD)) begin
      out_valid_nxt = 1'b1;
      out_pay_nxt   = res_pay_r;
      out_sts_nxt   = res_sts_r;
      out_cnt_nxt   = res_cnt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake outputs
  // ---------------------------------------------------------------------------
  assign in_ch.ready        = (state_r == dll_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.payload_out = out_pay_r;
  assign out_ch.status      = out_sts_r;
  assign out_ch.node_count  = out_cnt_r;

  // ---------------------------------------------------------------------------
  // Flops
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dll_pkg::ST_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      cur_r       <= NIL;
      free_top_r  <= '0;
      fresh_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_r       <= cur_nxt;
      free_top_r  <= free_top_nxt;
      fresh_r     <= fresh_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    data_r    <= data_nxt;
    tgt_r     <= tgt_nxt;
    node_r    <= node_nxt;
    after_r   <= after_nxt;
    out_pay_r <= out_pay_nxt;
    out_sts_r <= out_sts_nxt;
    out_cnt_r <= out_cnt_nxt;
    if (fin) begin
      res_pay_r <= res_pay_nxt;
      res_sts_r <= res_sts_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

endmodule
